[hdl/pale_pkg.sv]
// ----------------------------------------------------------------------------
// pale_pkg
// Shared types and constants for the positional array list engine.
// ----------------------------------------------------------------------------
package pale_pkg;

    localparam int PALE_DEPTH = 64;   // default list capacity
    localparam int RES_LIMIT  = 64;   // most results one display may give

    localparam int MODE_W   = 3;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 3;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_DISPLAY = 3'd0,
        MODE_INSERT  = 3'd1,
        MODE_DELETE  = 3'd2,
        MODE_SEARCH  = 3'd3,
        MODE_UPDATE  = 3'd4
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 3'd0,
        STAT_FULL     = 3'd1,
        STAT_BADPOS   = 3'd2,
        STAT_EMPTY    = 3'd3,
        STAT_NOTFOUND = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

endpackage

[hdl/pale_ram.sv]
// ----------------------------------------------------------------------------
// pale_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module pale_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/positional_array_list_engine_unit.sv]
// ----------------------------------------------------------------------------
// positional_array_list_engine_unit
// Packed list of signed 32-bit values with display, insert, delete, search
// and update requests, held in one synchronous RAM.
// ----------------------------------------------------------------------------
//
//  channel   | ports                                        | flow control
//  ----------+----------------------------------------------+-----------------
//  request   | start, mode, position, value                 | taken: start & !busy
//  result    | valid, status, index, element_value,         | one cycle per strobe,
//            | entry_count, last                            | no back-pressure
//
//  Update and rejects answer without a walk; insert moves each entry from the
//  top down to the position up one, then writes the new value into the gap;
//  delete moves each entry above the hole down one; search reads from index 0
//  to the first hit; display gives min(count, 64) results, one per cycle.
//  Reset clears the entry count and control only; the RAM needs no clearing.
//  The receiver cannot stall: each result shows for exactly one cycle.
//
module positional_array_list_engine_unit
    import pale_pkg::*;
#(
    parameter int DEPTH = PALE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [MODE_W-1:0]          mode,
    input  logic [POS_W-1:0]           position,
    input  logic signed [VAL_W-1:0]    value,
    output logic                       valid,
    output logic [STATUS_W-1:0]        status,
    output logic [INDEX_W-1:0]         index,
    output logic signed [VAL_W-1:0]    element_value,
    output logic [COUNT_W-1:0]         entry_count,
    output logic                       last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    // compare domain wide enough for both the count and the position port
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    state_t                 state_reg, state_next;
    mode_t                  op_reg, op_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [AW-1:0]          pos_reg, pos_next;
    logic [VAL_W-1:0]       val_reg, val_next;
    logic [AW-1:0]          rptr_reg, rptr_next;
    logic [CW-1:0]          left_reg, left_next;
    logic                   pv_reg, pv_next;
    logic [AW-1:0]          pidx_reg, pidx_next;

    logic                   valid_reg, valid_next;
    status_t                status_reg, status_next;
    logic [INDEX_W-1:0]     index_reg, index_next;
    logic [VAL_W-1:0]       elem_reg, elem_next;
    logic                   last_reg, last_next;

    logic                   ram_we, ram_re;
    logic [AW-1:0]          ram_waddr, ram_raddr;
    logic [VAL_W-1:0]       ram_wdata, ram_rdata;

    logic [XW-1:0]          cnt_x, pos_x, disp_x;
    logic                   accept;

    pale_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;
    assign cnt_x  = XW'(cnt_reg);
    assign pos_x  = XW'(position);
    assign disp_x = (cnt_x > XW'(RES_LIMIT)) ? XW'(RES_LIMIT) : cnt_x;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        rptr_next   = rptr_reg;
        left_next   = left_reg;
        pv_next     = 1'b0;
        pidx_next   = pidx_reg;
        valid_next  = 1'b0;
        status_next = status_reg;
        index_next  = index_reg;
        elem_next   = elem_reg;
        last_next   = last_reg;
        ram_we      = 1'b0;
        ram_waddr   = pos_reg;
        ram_wdata   = val_reg;
        ram_re      = 1'b0;
        ram_raddr   = rptr_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    // every immediate answer is a single closing result
                    index_next = '0;
                    elem_next  = '0;
                    last_next  = 1'b1;
                    op_next    = mode_t'(mode);
                    val_next   = value;
                    pos_next   = AW'(pos_x);
                    case (mode_t'(mode))
                        MODE_DISPLAY:
                        begin
                            if (cnt_reg == '0)
                            begin
                                valid_next  = 1'b1;
                                status_next = STAT_EMPTY;
                            end
                            else
                            begin
                                left_next  = CW'(disp_x);
                                rptr_next  = '0;
                                state_next = ST_WALK;
                            end
                        end
                        MODE_INSERT:
                        begin
                            if (cnt_x >= XW'(DEPTH))
                            begin
                                valid_next  = 1'b1;
                                status_next = STAT_FULL;
                            end
                            else if (pos_x > cnt_x)
                            begin
                                valid_next  = 1'b1;
                                status_next = STAT_BADPOS;
                            end
                            else
                            begin
                                // walk down from the top entry, moving each up one
                                left_next  = CW'(cnt_x - pos_x);
                                rptr_next  = AW'(cnt_x - XW'(1));
                                state_next = ST_WALK;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                valid_next  = 1'b1;
                                status_next = STAT_EMPTY;
                            end
                            else if (pos_x >= cnt_x)
                            begin
                                valid_next  = 1'b1;
                                status_next = STAT_BADPOS;
                            end
                            else
                            begin
                                // walk up from above the hole, moving each down one
                                left_next  = CW'(cnt_x - pos_x - XW'(1));
                                rptr_next  = AW'(pos_x + XW'(1));
                                state_next = ST_WALK;
                            end
                        end
                        MODE_SEARCH:
                        begin
                            left_next  = cnt_reg;
                            rptr_next  = '0;
                            state_next = ST_WALK;
                        end
                        MODE_UPDATE:
                        begin
                            valid_next = 1'b1;
                            if (pos_x >= cnt_x)
                            begin
                                status_next = STAT_BADPOS;
                            end
                            else
                            begin
                                ram_we      = 1'b1;
                                ram_waddr   = AW'(pos_x);
                                ram_wdata   = value;
                                status_next = STAT_OK;
                            end
                        end
                        default:
                        begin
                            valid_next  = 1'b1;
                            status_next = STAT_BADPOS;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                // issue one read per cycle; the registered data shows in the next cycle
                if (left_reg != '0)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = rptr_reg;
                    rptr_next = (op_reg == MODE_INSERT) ? rptr_reg - AW'(1)
                                                        : rptr_reg + AW'(1);
                    left_next = left_reg - CW'(1);
                    pv_next   = 1'b1;
                    pidx_next = rptr_reg;
                end

                case (op_reg)
                    MODE_DISPLAY:
                    begin
                        if (pv_reg)
                        begin
                            valid_next  = 1'b1;
                            status_next = STAT_OK;
                            index_next  = INDEX_W'(pidx_reg);
                            elem_next   = ram_rdata;
                            last_next   = (left_reg == '0);
                            if (left_reg == '0)
                            begin
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    MODE_INSERT:
                    begin
                        if (pv_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pidx_reg + AW'(1);
                            ram_wdata = ram_rdata;
                        end
                        else if (left_reg == '0)
                        begin
                            // shift done: drop the new value into the gap
                            ram_we      = 1'b1;
                            ram_waddr   = pos_reg;
                            ram_wdata   = val_reg;
                            cnt_next    = cnt_reg + CW'(1);
                            valid_next  = 1'b1;
                            status_next = STAT_OK;
                            state_next  = ST_IDLE;
                        end
                    end
                    MODE_DELETE:
                    begin
                        if (pv_reg)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = pidx_reg - AW'(1);
                            ram_wdata = ram_rdata;
                        end
                        else if (left_reg == '0)
                        begin
                            cnt_next    = cnt_reg - CW'(1);
                            valid_next  = 1'b1;
                            status_next = STAT_OK;
                            state_next  = ST_IDLE;
                        end
                    end
                    MODE_SEARCH:
                    begin
                        if (pv_reg && (ram_rdata == val_reg))
                        begin
                            // first hit wins; abandon the reads still in flight
                            valid_next  = 1'b1;
                            status_next = STAT_OK;
                            index_next  = INDEX_W'(pidx_reg);
                            pv_next     = 1'b0;
                            left_next   = '0;
                            state_next  = ST_IDLE;
                        end
                        else if (!pv_reg && (left_reg == '0))
                        begin
                            valid_next  = 1'b1;
                            status_next = STAT_NOTFOUND;
                            state_next  = ST_IDLE;
                        end
                    end
                    default:
                    begin
                        pv_next    = 1'b0;
                        left_next  = '0;
                        state_next = ST_IDLE;
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            left_reg  <= '0;
            pv_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            left_reg  <= left_next;
            pv_reg    <= pv_next;
            valid_reg <= valid_next;
        end
    end

    // payload and pointers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        rptr_reg   <= rptr_next;
        pidx_reg   <= pidx_next;
        status_reg <= status_next;
        index_reg  <= index_next;
        elem_reg   <= elem_next;
        last_reg   <= last_next;
    end

    assign valid         = valid_reg;
    assign status        = status_reg;
    assign index         = index_reg;
    assign element_value = elem_reg;
    assign entry_count   = COUNT_W'(cnt_reg);
    assign last          = last_reg;

`ifndef SYNTHESIS
    a_idle_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !pv_reg)
        else $error("read data pending while idle");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_x <= XW'(DEPTH))
        else $error("entry count above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == $past(cnt_reg)) || (cnt_reg == $past(cnt_reg) + CW'(1))
        || (cnt_reg == $past(cnt_reg) - CW'(1)))
        else $error("entry count moved by more than one");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode != MODE_DISPLAY)) |=> (busy || (valid && last)))
        else $error("request gave no closing result");

    a_count_only_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> (valid && last))
        else $error("entry count changed without a result");
`endif

endmodule
